// ===== rtl/rsa_pkg.sv =====
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared types and constants for the RPN stack ALU.
// ----------------------------------------------------------------------------
package rsa_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int CMD_W       = 3;
  localparam int DEPTH_W     = 5;
  localparam int ERR_W       = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 3'd0,
    CMD_ADD  = 3'd1,
    CMD_SUB  = 3'd2,
    CMD_MUL  = 3'd3,
    CMD_DIV  = 3'd4,
    CMD_MOD  = 3'd5,
    CMD_ABS  = 3'd6,
    CMD_DUP  = 3'd7
  } cmd_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_UNDER = 2'd1,
    ERR_OVER  = 2'd2,
    ERR_DIVZ  = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_FROM_ABOVE = 2'd1,
    CELL_FROM_BELOW = 2'd2
  } cell_op_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quo;
    logic [DATA_W-1:0] rem;
  } div_rsp_t;

endpackage

// ===== rtl/rsa_cell.sv =====
// ----------------------------------------------------------------------------
// rsa_cell
// One stack entry: holds its word, or takes the word of its upper or lower
// neighbor.
// ----------------------------------------------------------------------------
module rsa_cell (
  input  logic                      clk,
  input  rsa_pkg::cell_op_t         op,
  input  logic [rsa_pkg::DATA_W-1:0] above,
  input  logic [rsa_pkg::DATA_W-1:0] below,
  output logic [rsa_pkg::DATA_W-1:0] data
);

  logic [rsa_pkg::DATA_W-1:0] data_r;

  always_ff @(posedge clk) begin
    case (op)
      rsa_pkg::CELL_FROM_ABOVE: data_r <= above;
      rsa_pkg::CELL_FROM_BELOW: data_r <= below;
      default:                  data_r <= data_r;
    endcase
  end

  assign data = data_r;

endmodule

// ===== rtl/rsa_div.sv =====
// ----------------------------------------------------------------------------
// rsa_div
// Signed 32-bit divider, restoring, one quotient bit per cycle.
// Quotient truncates toward zero; remainder takes the dividend's sign.
// ----------------------------------------------------------------------------
module rsa_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [rsa_pkg::DATA_W-1:0] dividend,
  input  logic [rsa_pkg::DATA_W-1:0] divisor,
  output rsa_pkg::div_rsp_t          rsp
);

  localparam int W     = rsa_pkg::DATA_W;
  localparam int STP_W = $clog2(W);

  typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_DONE} dv_state_t;

  dv_state_t      state_r;
  logic [W-1:0]   q_r;
  logic [W-1:0]   r_r;
  logic [W-1:0]   d_r;
  logic [STP_W-1:0] cnt_r;
  logic           negq_r;
  logic           negr_r;

  logic [W:0]     rem_sh;
  logic [W:0]     diff;
  logic           ge;

  assign rem_sh = {r_r, q_r[W-1]};
  assign diff   = rem_sh - {1'b0, d_r};
  assign ge     = ~diff[W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
    end else begin
      unique case (state_r)
        DV_IDLE: begin
          if (start) begin
            q_r     <= dividend[W-1] ? (W'(0) - dividend) : dividend;
            d_r     <= divisor[W-1] ? (W'(0) - divisor) : divisor;
            r_r     <= '0;
            cnt_r   <= '0;
            negq_r  <= dividend[W-1] ^ divisor[W-1];
            negr_r  <= dividend[W-1];
            state_r <= DV_RUN;
          end
        end
        DV_RUN: begin
          r_r   <= ge ? diff[W-1:0] : rem_sh[W-1:0];
          q_r   <= {q_r[W-2:0], ge};
          cnt_r <= cnt_r + STP_W'(1);
          if (cnt_r == STP_W'(W - 1)) begin
            state_r <= DV_DONE;
          end
        end
        DV_DONE: begin
          state_r <= DV_IDLE;
        end
        default: begin
          state_r <= DV_IDLE;
        end
      endcase
    end
  end

  assign rsp.done = (state_r == DV_DONE);
  assign rsp.quo  = negq_r ? (W'(0) - q_r) : q_r;
  assign rsp.rem  = negr_r ? (W'(0) - r_r) : r_r;

endmodule

// ===== rtl/rpn_stack_alu.sv =====
// ----------------------------------------------------------------------------
// rpn_stack_alu
// 32-bit integer RPN stack machine on a shifting stack of cells.
// ----------------------------------------------------------------------------
// Input stream (in_*): one instruction word per handshake, cmd and value in
// in_tdata. Output stream (out_*): exactly one result word per instruction,
// with top of stack, depth and error code.
// The stack is a row of cells; push and dup shift it down, binary ops
// shift it up, abs rewrites the top cell. Errors leave the stack unchanged.
// Path from accept to result valid: ST_EXEC, then ST_RESULT, for push, add,
// sub, mul, abs, dup and any error; ST_EXEC, ST_DIV, then ST_RESULT for div
// and mod, with ST_DIV waiting on the 32-step restoring divider. One
// instruction is in flight at a time, so a new word is taken only after the previous result is written.
// The result sits in an output register; the next instruction is accepted
// and executed while it waits. If the receiver stalls, the following
// result holds inside the block and in_tready stays low until the output
// register frees.
// Reset (rst_n low, synchronous) empties the stack and drops out_tvalid.
// Stack contents above the depth are never shown.
// ----------------------------------------------------------------------------
module rpn_stack_alu (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [rsa_pkg::IN_TDATA_W-1:0]  in_tdata,   // cmd[2:0], value[34:3]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rsa_pkg::OUT_TDATA_W-1:0] out_tdata   // top[31:0], depth[36:32], error[38:37]
);

  localparam int W  = rsa_pkg::DATA_W;
  localparam int N  = rsa_pkg::STACK_DEPTH;
  localparam int CW = rsa_pkg::CNT_W;

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_DIV, ST_RESULT} state_t;

  state_t                      state_r;
  rsa_pkg::cmd_t               cmd_r;
  logic [W-1:0]                val_r;
  rsa_pkg::err_t               err_r;
  logic [CW-1:0]               count_r;
  logic                        out_valid_r;
  logic [W-1:0]                out_top_r;
  logic [rsa_pkg::DEPTH_W-1:0] out_depth_r;
  rsa_pkg::err_t               out_err_r;

  logic [W-1:0]      stk [N];
  rsa_pkg::cell_op_t cop_top;
  rsa_pkg::cell_op_t cop_rest;
  logic [W-1:0]      top_new;
  logic [CW-1:0]     count_nxt;
  rsa_pkg::err_t     err_nxt;
  logic              div_start;
  rsa_pkg::div_rsp_t div_rsp;
  logic [W-1:0]      opa;
  logic [W-1:0]      opb;
  logic [W-1:0]      alu_res;
  logic              is_empty;
  logic              is_full;
  logic              lt_two;
  logic              out_free;

  assign opb      = stk[0];
  assign opa      = stk[1];
  assign is_empty = (count_r == CW'(0));
  assign is_full  = (count_r == CW'(N));
  assign lt_two   = (count_r < CW'(2));
  assign out_free = ~out_valid_r | out_tready;

  always_comb begin
    case (cmd_r)
      rsa_pkg::CMD_ADD: alu_res = opa + opb;
      rsa_pkg::CMD_SUB: alu_res = opa - opb;
      default:          alu_res = opa * opb;
    endcase
  end

  always_comb begin
    err_nxt   = rsa_pkg::ERR_OK;
    cop_top   = rsa_pkg::CELL_HOLD;
    cop_rest  = rsa_pkg::CELL_HOLD;
    top_new   = opb;
    count_nxt = count_r;
    div_start = 1'b0;
    if (state_r == ST_EXEC) begin
      case (cmd_r)
        rsa_pkg::CMD_PUSH: begin
          if (is_full) begin
            err_nxt = rsa_pkg::ERR_OVER;
          end else begin
            top_new   = val_r;
            cop_top   = rsa_pkg::CELL_FROM_ABOVE;
            cop_rest  = rsa_pkg::CELL_FROM_ABOVE;
            count_nxt = count_r + CW'(1);
          end
        end
        rsa_pkg::CMD_ABS: begin
          if (is_empty) begin
            err_nxt = rsa_pkg::ERR_UNDER;
          end else begin
            top_new = opb[W-1] ? (W'(0) - opb) : opb;
            cop_top = rsa_pkg::CELL_FROM_ABOVE;
          end
        end
        rsa_pkg::CMD_DUP: begin
          if (is_empty) begin
            err_nxt = rsa_pkg::ERR_UNDER;
          end else if (is_full) begin
            err_nxt = rsa_pkg::ERR_OVER;
          end else begin
            cop_top   = rsa_pkg::CELL_FROM_ABOVE;
            cop_rest  = rsa_pkg::CELL_FROM_ABOVE;
            count_nxt = count_r + CW'(1);
          end
        end
        rsa_pkg::CMD_DIV, rsa_pkg::CMD_MOD: begin
          if (lt_two) begin
            err_nxt = rsa_pkg::ERR_UNDER;
          end else if (opb == W'(0)) begin
            err_nxt = rsa_pkg::ERR_DIVZ;
          end else begin
            div_start = 1'b1;
          end
        end
        default: begin
          if (lt_two) begin
            err_nxt = rsa_pkg::ERR_UNDER;
          end else begin
            top_new   = alu_res;
            cop_top   = rsa_pkg::CELL_FROM_ABOVE;
            cop_rest  = rsa_pkg::CELL_FROM_BELOW;
            count_nxt = count_r - CW'(1);
          end
        end
      endcase
    end else if (state_r == ST_DIV && div_rsp.done) begin
      top_new   = (cmd_r == rsa_pkg::CMD_DIV) ? div_rsp.quo : div_rsp.rem;
      cop_top   = rsa_pkg::CELL_FROM_ABOVE;
      cop_rest  = rsa_pkg::CELL_FROM_BELOW;
      count_nxt = count_r - CW'(1);
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < N; gi++) begin : g_cell
      logic [W-1:0]      above;
      logic [W-1:0]      below;
      rsa_pkg::cell_op_t op;
      if (gi == 0) begin : g_top
        assign above = top_new;
        assign op    = cop_top;
      end else begin : g_mid
        assign above = stk[gi-1];
        assign op    = cop_rest;
      end
      if (gi == N - 1) begin : g_last
        assign below = '0;
      end else begin : g_next
        assign below = stk[gi+1];
      end
      rsa_cell u_cell (
        .clk   (clk),
        .op    (op),
        .above (above),
        .below (below),
        .data  (stk[gi])
      );
    end
  endgenerate

  rsa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (opa),
    .divisor  (opb),
    .rsp      (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (out_valid_r && out_tready && state_r != ST_RESULT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            cmd_r   <= rsa_pkg::cmd_t'(in_tdata[rsa_pkg::CMD_W-1:0]);
            val_r   <= in_tdata[rsa_pkg::CMD_W +: W];
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          err_r   <= err_nxt;
          state_r <= div_start ? ST_DIV : ST_RESULT;
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            state_r <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_top_r   <= is_empty ? W'(0) : stk[0];
            out_depth_r <= rsa_pkg::DEPTH_W'(count_r);
            out_err_r   <= err_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_err_r, out_depth_r, out_top_r};

endmodule

// ===== rtl/rsa_checker.sv =====
// ----------------------------------------------------------------------------
// rsa_checker
// Port-level checks for the RPN stack ALU, bound to the top level.
// ----------------------------------------------------------------------------
module rsa_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [rsa_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [rsa_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic       in_fire;
  logic [4:0] depth;
  logic [1:0] err;

  assign in_fire = in_tvalid & in_tready;
  assign depth   = out_tdata[36:32];
  assign err     = out_tdata[38:37];

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && depth == 5'd0 && (rsa_pkg::STACK_DEPTH < 32)
      |-> out_tdata[31:0] == 32'd0)
    else $error("empty stack shows nonzero top");

  a_divz_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && err == rsa_pkg::ERR_DIVZ && (rsa_pkg::STACK_DEPTH < 32)
      |-> depth >= 5'd2)
    else $error("divide by zero reported with fewer than two entries");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("second word accepted while one is executing");

endmodule

bind rpn_stack_alu rsa_checker u_rsa_checker (.*);
